@@ src/sparse_column_slot_store_macros.svh @@
`ifndef SPARSE_COLUMN_SLOT_STORE_MACROS_SVH
`define SPARSE_COLUMN_SLOT_STORE_MACROS_SVH

// Both macros expect clk and rst_n in the enclosing scope.

// Implication in the same cycle.
`define SCCS_ASSERT_NOW(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed: same-cycle check");

// Implication into the next cycle.
`define SCCS_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed: next-cycle check");

`endif

@@ src/sccs_pkg.sv @@
`default_nettype none

package sccs_pkg;

  localparam int ROW_W      = 12;
  localparam int COL_W      = 6;
  localparam int WORD_W     = 64;
  localparam int STATUS_W   = 2;
  localparam int ROWS_CFG_W = 13;
  localparam int COLS_CFG_W = 7;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BOUNDS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 1'b1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK
  } state_t;

  // Outcome of one column update, handed from the slot logic to the top level.
  typedef struct packed {
    logic                write_back;
    logic [STATUS_W-1:0] status;
  } upd_res_t;

endpackage

`default_nettype wire

@@ src/sccs_channels.sv @@
`default_nettype none

interface sccs_in_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [sccs_pkg::ROW_W-1:0]  row_index;
  logic [sccs_pkg::COL_W-1:0]  col_index;
  logic [sccs_pkg::WORD_W-1:0] write_word;

  modport source (output valid, operation, row_index, col_index, write_word, input ready);
  modport sink (input valid, operation, row_index, col_index, write_word, output ready);
endinterface

interface sccs_out_if;
  logic                          valid;
  logic                          ready;
  logic [sccs_pkg::WORD_W-1:0]   read_word;
  logic [sccs_pkg::STATUS_W-1:0] status;

  modport source (output valid, read_word, status, input ready);
  modport sink (input valid, read_word, status, output ready);
endinterface

`default_nettype wire

@@ src/sparse_column_slot_store.sv @@
// Channel  Direction  Payload                                          Handshake
// in_ch    sink       operation, row_index, col_index, write_word      valid/ready
// out_ch   source     read_word, status                                valid/ready
// cfg_*    sink       cfg_index selects register, cfg_wdata            cfg_we, no wait
//
// The column line is read from the column memory in the cycle a word is accepted,
// then searched, updated and written back in S_LOOK; no new word is accepted before
// the write-back, as each column is one memory line read, modified and written.
// After reset a clearing pass writes every column line empty, one line a cycle, so
// in_ch.ready stays low until the pass is done. A result waiting on out_ch does not
// block acceptance; the update cycle holds until the output register is free.
`default_nettype none

module sparse_column_slot_store #(
  parameter int NUM_COLS      = 64,
  parameter int SLOTS_PER_COL = 8,
  parameter int MAX_ROWS      = 4096
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  sccs_in_if.sink                                 in_ch,
  sccs_out_if.source                              out_ch,
  input  wire logic                               cfg_we,
  input  wire logic [sccs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [sccs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

`include "sparse_column_slot_store_macros.svh"

  localparam int LINE_W = SLOTS_PER_COL * (1 + sccs_pkg::ROW_W + sccs_pkg::WORD_W);
  localparam int CW     = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1;
  localparam logic [CW-1:0] LAST_COL = CW'(NUM_COLS - 1);

  sccs_pkg::state_t state_r, state_nxt;

  logic [sccs_pkg::ROWS_CFG_W-1:0] rows_in_use_r;
  logic [sccs_pkg::COLS_CFG_W-1:0] cols_in_use_r;

  logic [CW-1:0] clr_cnt_r, clr_cnt_nxt;

  logic                        op_r;
  logic [sccs_pkg::ROW_W-1:0]  row_r;
  logic [sccs_pkg::COL_W-1:0]  col_r;
  logic [sccs_pkg::WORD_W-1:0] word_r;

  logic                          out_valid_r, out_valid_nxt;
  logic [sccs_pkg::WORD_W-1:0]   out_word_r;
  logic [sccs_pkg::STATUS_W-1:0] out_status_r;

  logic [LINE_W-1:0] col_mem [NUM_COLS];
  logic [LINE_W-1:0] rd_line_r;

  logic              in_accept;
  logic              lookup_go;
  logic              in_bounds;
  logic              mem_we;
  logic [CW-1:0]     mem_waddr;
  logic [LINE_W-1:0] mem_wdata;
  logic [LINE_W-1:0] upd_line;
  logic [sccs_pkg::WORD_W-1:0] upd_word;
  sccs_pkg::upd_res_t          upd_res;

  assign in_accept = in_ch.valid && in_ch.ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sccs_pkg::S_CLEAR: begin
        if (clr_cnt_r == LAST_COL) state_nxt = sccs_pkg::S_IDLE;
      end
      sccs_pkg::S_IDLE: begin
        if (in_accept) state_nxt = sccs_pkg::S_LOOK;
      end
      sccs_pkg::S_LOOK: begin
        if (lookup_go) state_nxt = sccs_pkg::S_IDLE;
      end
      default: state_nxt = sccs_pkg::S_CLEAR;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ch.ready = 1'b0;
    lookup_go   = 1'b0;
    clr_cnt_nxt = clr_cnt_r;
    unique case (state_r)
      sccs_pkg::S_CLEAR: clr_cnt_nxt = clr_cnt_r + CW'(1);
      sccs_pkg::S_IDLE:  in_ch.ready = 1'b1;
      sccs_pkg::S_LOOK:  lookup_go = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  assign in_bounds = ({1'b0, row_r} < rows_in_use_r) &&
                     (32'(row_r) < 32'(MAX_ROWS)) &&
                     ({1'b0, col_r} < cols_in_use_r) &&
                     (32'(col_r) < 32'(NUM_COLS));

  sccs_col_update #(
    .SLOTS_PER_COL (SLOTS_PER_COL)
  ) u_update (
    .operation  (op_r),
    .row_index  (row_r),
    .write_word (word_r),
    .line_i     (rd_line_r),
    .line_o     (upd_line),
    .read_word  (upd_word),
    .res        (upd_res)
  );

  // An all-zero line has every valid bit low, so the clearing pass writes zeros.
  always_comb begin
    if (state_r == sccs_pkg::S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else begin
      mem_we    = lookup_go && in_bounds && upd_res.write_back;
      mem_waddr = CW'(col_r);
      mem_wdata = upd_line;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) col_mem[mem_waddr] <= mem_wdata;
    if (in_accept) rd_line_r <= col_mem[CW'(in_ch.col_index)];
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (lookup_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= sccs_pkg::S_CLEAR;
      clr_cnt_r     <= '0;
      out_valid_r   <= 1'b0;
      rows_in_use_r <= '0;
      cols_in_use_r <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          sccs_pkg::CFG_ROWS_IN_USE: rows_in_use_r <= cfg_wdata;
          sccs_pkg::CFG_COLS_IN_USE:
            cols_in_use_r <= cfg_wdata[sccs_pkg::COLS_CFG_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r   <= in_ch.operation;
      row_r  <= in_ch.row_index;
      col_r  <= in_ch.col_index;
      word_r <= in_ch.write_word;
    end
    if (lookup_go) begin
      out_word_r   <= in_bounds ? upd_word : '0;
      out_status_r <= in_bounds ? upd_res.status : sccs_pkg::ST_BOUNDS;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_word = out_word_r;
  assign out_ch.status    = out_status_r;

  `SCCS_ASSERT_NEXT(a_accept_to_look, in_accept, state_r == sccs_pkg::S_LOOK)
  `SCCS_ASSERT_NEXT(a_look_gives_result, lookup_go, out_valid_r)
  `SCCS_ASSERT_NOW(a_bounds_zero_word, out_valid_r && (out_status_r == sccs_pkg::ST_BOUNDS), out_word_r == '0)
  `SCCS_ASSERT_NOW(a_no_write_out_of_bounds, lookup_go && !in_bounds, !mem_we)

endmodule

`default_nettype wire

@@ src/sccs_col_update.sv @@
`default_nettype none

module sccs_col_update #(
  parameter int SLOTS_PER_COL = 8
) (
  input  wire logic                                  operation,
  input  wire logic [sccs_pkg::ROW_W-1:0]            row_index,
  input  wire logic [sccs_pkg::WORD_W-1:0]           write_word,
  input  wire logic [SLOTS_PER_COL*(1+sccs_pkg::ROW_W+sccs_pkg::WORD_W)-1:0] line_i,
  output logic      [SLOTS_PER_COL*(1+sccs_pkg::ROW_W+sccs_pkg::WORD_W)-1:0] line_o,
  output logic      [sccs_pkg::WORD_W-1:0]           read_word,
  output sccs_pkg::upd_res_t                         res
);

  typedef struct packed {
    logic [SLOTS_PER_COL-1:0]                        valid;
    logic [SLOTS_PER_COL-1:0][sccs_pkg::ROW_W-1:0]   row;
    logic [SLOTS_PER_COL-1:0][sccs_pkg::WORD_W-1:0]  word;
  } line_t;

  line_t                       cur;
  line_t                       nxt;
  logic [SLOTS_PER_COL-1:0]    hit;
  logic [SLOTS_PER_COL-1:0]    hit_oh;
  logic [SLOTS_PER_COL-1:0]    empty_oh;
  logic [sccs_pkg::WORD_W-1:0] hit_word;
  logic                        nonzero;

  assign cur = line_i;

  // Everything except the sign bit must be zero for a delete.
  assign nonzero = |write_word[sccs_pkg::WORD_W-2:0];

  always_comb begin
    for (int k = 0; k < SLOTS_PER_COL; k++) begin
      hit[k] = cur.valid[k] && (cur.row[k] == row_index);
    end
  end

  // Lowest matching slot and lowest empty slot, both as one-hot vectors.
  assign hit_oh   = hit & (~hit + SLOTS_PER_COL'(1));
  assign empty_oh = ~cur.valid & (cur.valid + SLOTS_PER_COL'(1));

  always_comb begin
    hit_word = '0;
    for (int k = 0; k < SLOTS_PER_COL; k++) begin
      hit_word = hit_word | (cur.word[k] & {sccs_pkg::WORD_W{hit_oh[k]}});
    end
  end

  always_comb begin
    nxt            = cur;
    res.write_back = 1'b0;
    res.status     = sccs_pkg::ST_OK;
    read_word      = (operation == sccs_pkg::OP_READ) ? hit_word : '0;
    if (operation == sccs_pkg::OP_WRITE) begin
      if (|hit) begin
        res.write_back = 1'b1;
        for (int k = 0; k < SLOTS_PER_COL; k++) begin
          if (hit_oh[k]) begin
            if (nonzero) begin
              nxt.word[k] = write_word;
            end else begin
              nxt.valid[k] = 1'b0;
            end
          end
        end
      end else if (|empty_oh) begin
        res.write_back = nonzero;
        for (int k = 0; k < SLOTS_PER_COL; k++) begin
          if (empty_oh[k]) begin
            nxt.valid[k] = 1'b1;
            nxt.row[k]   = row_index;
            nxt.word[k]  = write_word;
          end
        end
      end else begin
        res.status = sccs_pkg::ST_FULL;
      end
    end
  end

  assign line_o = nxt;

endmodule

`default_nettype wire

@@ verif/sparse_column_slot_store_tb.sv @@
`default_nettype none

module sparse_column_slot_store_tb;

  localparam int NUM_COLS      = 64;
  localparam int SLOTS         = 8;
  localparam int TOTAL_SLOTS   = NUM_COLS * SLOTS;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 400000;
  localparam logic [sccs_pkg::WORD_W-1:0] MAG_MASK   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [sccs_pkg::WORD_W-1:0] NEG_ZERO   = 64'h8000_0000_0000_0000;
  localparam logic [sccs_pkg::WORD_W-1:0] QUIET_NAN  = 64'h7FF8_0000_0000_0001;
  localparam logic [sccs_pkg::WORD_W-1:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef logic [sccs_pkg::ROW_W-1:0] row_t;
  typedef logic [sccs_pkg::COL_W-1:0] col_t;

  typedef struct packed {
    logic                        op;
    row_t                        row;
    col_t                        col;
    logic [sccs_pkg::WORD_W-1:0] word;
  } access_t;

  typedef struct packed {
    logic [sccs_pkg::WORD_W-1:0]   read_word;
    logic [sccs_pkg::STATUS_W-1:0] status;
  } answer_t;

  logic clk;
  logic rst_n;
  logic                            cfg_we;
  logic [sccs_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [sccs_pkg::CFG_DATA_W-1:0] cfg_wdata;

  sccs_in_if  in_ch ();
  sccs_out_if out_ch ();

  sparse_column_slot_store dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the column store and its limits.
  bit                              shadow_valid [TOTAL_SLOTS];
  row_t                            shadow_row   [TOTAL_SLOTS];
  logic [sccs_pkg::WORD_W-1:0]     shadow_word  [TOTAL_SLOTS];
  logic [sccs_pkg::ROWS_CFG_W-1:0] rows_lim;
  logic [sccs_pkg::COLS_CFG_W-1:0] cols_lim;

  answer_t pending_answers [$];
  answer_t oldest_answer;
  int      mismatch_count;
  int unsigned cycle_count;

  bit sender_gaps_on;
  bit receiver_stalls_on;
  bit hold_request;
  int hold_left;
  int stall_left;
  int hot_row;
  int hot_col;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off counted here on request.
  initial begin
    out_ch.ready <= 1'b0;
    hold_left = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (receiver_stalls_on && $urandom_range(0, 99) < 20) begin
        if ($urandom_range(0, 99) < 90) stall_left = $urandom_range(0, 2);
        else stall_left = $urandom_range(10, 40);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_answers.size() == 0) begin
        $error("result with nothing outstanding: read_word %h status %0d",
               out_ch.read_word, out_ch.status);
        mismatch_count++;
      end else begin
        oldest_answer = pending_answers.pop_front();
        if (out_ch.read_word !== oldest_answer.read_word) begin
          $error("read_word: expected %h, got %h",
                 oldest_answer.read_word, out_ch.read_word);
          mismatch_count++;
        end
        if (out_ch.status !== oldest_answer.status) begin
          $error("status: expected %0d, got %0d", oldest_answer.status, out_ch.status);
          mismatch_count++;
        end
      end
    end
  end

  // Expected answer for one accepted word; updates the shadow store as the block would.
  function automatic answer_t column_access(access_t a);
    answer_t ans;
    int      slot;
    int      empty_at;
    bit      found;
    bit      have_empty;
    bit      nonzero;
    ans.read_word = '0;
    ans.status = sccs_pkg::ST_OK;
    found = 1'b0;
    have_empty = 1'b0;
    empty_at = 0;
    nonzero = (a.word & MAG_MASK) != '0;
    if (a.row >= rows_lim || a.col >= cols_lim) begin
      ans.status = sccs_pkg::ST_BOUNDS;
      return ans;
    end
    for (int k = 0; k < SLOTS; k++) begin
      slot = a.col * SLOTS + k;
      if (!found) begin
        if (shadow_valid[slot] && shadow_row[slot] == a.row) begin
          found = 1'b1;
          if (a.op == sccs_pkg::OP_READ) ans.read_word = shadow_word[slot];
          else if (nonzero) shadow_word[slot] = a.word;
          else shadow_valid[slot] = 1'b0;
        end else if (!have_empty && !shadow_valid[slot]) begin
          have_empty = 1'b1;
          empty_at = slot;
        end
      end
    end
    if (!found && a.op == sccs_pkg::OP_WRITE) begin
      if (!have_empty) begin
        ans.status = sccs_pkg::ST_FULL;
      end else if (nonzero) begin
        shadow_valid[empty_at] = 1'b1;
        shadow_row[empty_at] = a.row;
        shadow_word[empty_at] = a.word;
      end
    end
    return ans;
  endfunction

  function automatic access_t pack_access(logic op, int row, int col,
                                          logic [sccs_pkg::WORD_W-1:0] w);
    access_t a;
    a.op = op;
    a.row = row[sccs_pkg::ROW_W-1:0];
    a.col = col[sccs_pkg::COL_W-1:0];
    a.word = w;
    return a;
  endfunction

  // Many words address a few hot rows and a few hot columns so that hits,
  // deletes and full columns come up often.
  function automatic access_t random_access();
    access_t a;
    a.op = 1'($urandom_range(0, 1));
    if (rows_lim == 0 || $urandom_range(0, 99) < 8)
      a.row = row_t'($urandom_range(0, 4095));
    else if ($urandom_range(0, 99) < 60)
      a.row = row_t'((hot_row + $urandom_range(0, 11)) % rows_lim);
    else
      a.row = row_t'($urandom_range(0, rows_lim - 1));
    if (cols_lim == 0 || $urandom_range(0, 99) < 8)
      a.col = col_t'($urandom_range(0, 63));
    else if ($urandom_range(0, 99) < 70)
      a.col = col_t'((hot_col + $urandom_range(0, 2)) % cols_lim);
    else
      a.col = col_t'($urandom_range(0, cols_lim - 1));
    case ($urandom_range(0, 9))
      0: a.word = $urandom_range(0, 1) ? NEG_ZERO : '0;
      1: begin
        case ($urandom_range(0, 3))
          0: a.word = QUIET_NAN;
          1: a.word = ALL_ONES;
          2: a.word = 64'd1;
          default: a.word = NEG_ZERO | 64'd1;
        endcase
      end
      default: a.word = {$urandom, $urandom};
    endcase
    return a;
  endfunction

  task automatic offer_word(access_t a);
    int gap;
    in_ch.operation  <= a.op;
    in_ch.row_index  <= a.row;
    in_ch.col_index  <= a.col;
    in_ch.write_word <= a.word;
    in_ch.valid      <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_answers.push_back(column_access(a));
    gap = 0;
    if (sender_gaps_on) begin
      if ($urandom_range(0, 99) >= 65) begin
        if ($urandom_range(0, 99) < 85) gap = $urandom_range(1, 3);
        else gap = $urandom_range(8, 30);
      end
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait for every outstanding result, then let the block settle.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(logic [sccs_pkg::CFG_IDX_W-1:0] idx, int value);
    cfg_index <= idx;
    cfg_wdata <= value[sccs_pkg::CFG_DATA_W-1:0];
    cfg_we    <= 1'b1;
    @(posedge clk);
    if (idx == sccs_pkg::CFG_ROWS_IN_USE) rows_lim = value[sccs_pkg::ROWS_CFG_W-1:0];
    else cols_lim = value[sccs_pkg::COLS_CFG_W-1:0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_limits(int rows, int cols);
    write_register(sccs_pkg::CFG_ROWS_IN_USE, rows);
    write_register(sccs_pkg::CFG_COLS_IN_USE, cols);
  endtask

  // Both limits are zero after reset, so every access is out of bounds.
  task automatic test_unconfigured();
    offer_word(pack_access(sccs_pkg::OP_READ, 0, 0, '0));
    offer_word(pack_access(sccs_pkg::OP_WRITE, 5, 3, 64'h3FF0_0000_0000_0000));
    drain_results();
  endtask

  task automatic test_extremes();
    set_limits(4096, 64);
    offer_word(pack_access(sccs_pkg::OP_WRITE, 4095, 63, ALL_ONES));
    offer_word(pack_access(sccs_pkg::OP_READ, 4095, 63, '0));
    offer_word(pack_access(sccs_pkg::OP_WRITE, 0, 0, 64'd1));
    offer_word(pack_access(sccs_pkg::OP_READ, 0, 0, ALL_ONES));
    offer_word(pack_access(sccs_pkg::OP_WRITE, 0, 0, NEG_ZERO));
    offer_word(pack_access(sccs_pkg::OP_READ, 0, 0, '0));
    offer_word(pack_access(sccs_pkg::OP_WRITE, 7, 0, '0));
    offer_word(pack_access(sccs_pkg::OP_WRITE, 9, 1, QUIET_NAN));
    offer_word(pack_access(sccs_pkg::OP_READ, 9, 1, '0));
    drain_results();
  endtask

  // Fill one column, overflow it, then update, delete and refill a slot.
  task automatic test_column_full();
    for (int r = 10; r < 18; r++)
      offer_word(pack_access(sccs_pkg::OP_WRITE, r, 2, {$urandom, $urandom} | 64'd1));
    offer_word(pack_access(sccs_pkg::OP_WRITE, 18, 2, 64'h1234));
    offer_word(pack_access(sccs_pkg::OP_WRITE, 19, 2, '0));
    offer_word(pack_access(sccs_pkg::OP_WRITE, 13, 2, 64'h4000_0000_0000_0000));
    offer_word(pack_access(sccs_pkg::OP_WRITE, 12, 2, NEG_ZERO));
    offer_word(pack_access(sccs_pkg::OP_WRITE, 20, 2, 64'hDEAD_BEEF));
    offer_word(pack_access(sccs_pkg::OP_READ, 20, 2, '0));
    drain_results();
  endtask

  task automatic test_bounds_edges();
    set_limits(100, 5);
    offer_word(pack_access(sccs_pkg::OP_READ, 100, 0, '0));
    offer_word(pack_access(sccs_pkg::OP_WRITE, 99, 5, 64'h55));
    offer_word(pack_access(sccs_pkg::OP_WRITE, 99, 4, 64'h77));
    offer_word(pack_access(sccs_pkg::OP_READ, 99, 4, '0));
    drain_results();
  endtask

  // The receiver holds off for a long stretch while words keep coming, so
  // the block fills up and has to stall its input.
  task automatic test_backpressure();
    set_limits(4096, 64);
    sender_gaps_on = 1'b0;
    hot_row = $urandom_range(0, 4095);
    hot_col = $urandom_range(0, 63);
    hold_request = 1'b1;
    repeat (24) offer_word(random_access());
    drain_results();
  endtask

  task automatic run_random_phase(int rows, int cols, int count, bit gaps, bit stalls);
    set_limits(rows, cols);
    sender_gaps_on = gaps;
    receiver_stalls_on = stalls;
    hot_row = $urandom_range(0, 4095);
    hot_col = $urandom_range(0, 63);
    for (int n = 0; n < count; n++) begin
      offer_word(random_access());
      // Now and then the sender pauses until every result is back.
      if ($urandom_range(0, 99) == 0) drain_results();
    end
    drain_results();
  endtask

  task automatic test_random();
    run_random_phase(4096, 64, 200, 1'b1, 1'b1);
    run_random_phase(16, 4, 250, 1'b1, 1'b1);
    run_random_phase(1, 1, 60, 1'b0, 1'b0);
    run_random_phase(4096, 1, 150, 1'b1, 1'b0);
    run_random_phase(37, 64, 150, 1'b0, 1'b1);
    run_random_phase(0, 64, 30, 1'b1, 1'b1);
    run_random_phase(4096, 0, 30, 1'b0, 1'b1);
    run_random_phase(4096, 64, 180, 1'b0, 1'b0);
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.operation  <= sccs_pkg::OP_READ;
    in_ch.row_index  <= '0;
    in_ch.col_index  <= '0;
    in_ch.write_word <= '0;
    cfg_we           <= 1'b0;
    cfg_index        <= sccs_pkg::CFG_ROWS_IN_USE;
    cfg_wdata        <= '0;
    mismatch_count = 0;
    rows_lim = '0;
    cols_lim = '0;
    hold_request = 1'b0;
    sender_gaps_on = 1'b1;
    receiver_stalls_on = 1'b1;
    for (int s = 0; s < TOTAL_SLOTS; s++) begin
      shadow_valid[s] = 1'b0;
      shadow_row[s] = '0;
      shadow_word[s] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_unconfigured();
    test_extremes();
    test_column_full();
    test_bounds_edges();
    test_backpressure();
    test_random();

    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_answers.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sparse_column_slot_store.f @@
+incdir+src
src/sccs_pkg.sv
src/sccs_channels.sv
src/sccs_col_update.sv
src/sparse_column_slot_store.sv
verif/sparse_column_slot_store_tb.sv
